// ----- rtl/core/kmct_pkg.sv -----
// kmct_pkg: shared constants for the keyed mistake count table core.
// Field widths, command and status codes, register indexes and defaults.
// No dependencies.
package kmct_pkg;

  localparam int DEF_TEXT_DEPTH  = 1024;
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int FUNC_W     = 3;
  localparam int IDX_W      = 10;
  localparam int KEY_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int ECOUNT_W   = 16;
  localparam int EUSED_W    = 9;
  localparam int CURSOR_W   = 11;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_KEY   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RANK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PAST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_B  = 2'd2;

  localparam logic [KEY_W-1:0] ERASE_A_RST = 8'd8;
  localparam logic [KEY_W-1:0] ERASE_B_RST = 8'd127;

endpackage

// ----- rtl/core/keyed_mistake_count_table_core.sv -----
// keyed_mistake_count_table_core: typing-mistake counter with key-sorted table.
// Text and table live in synchronous memories; a sequencer reads, modifies, writes.
// Depends on kmct_pkg.
// Load, erase, past-end and unknown func go straight to the result; read fetches one
// entry; a text hit compares the key with the text at the cursor; a mistake on a known key
// is found by linear search, on a new key by linear search, then shift-insert per moved entry.
// Rank and the key reorder before a mistake after rank are bubble passes over the
// table, at most entries_used passes; rank then reads entry 0 when the table is not empty.
// Clear sweeps the text memory. One item in flight: in_tready returns in the same
// cycle as out_tvalid rises; a held result stalls the sequencer.
// Reset (synchronous, rst_n low): empty table, cursor 0, registers at defaults.
module keyed_mistake_count_table_core
  import kmct_pkg::*;
#(
  parameter int TEXT_DEPTH  = DEF_TEXT_DEPTH,
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // func[2:0], index[12:3], key[20:13], zero pad
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], mismatch[2], entry_key[10:3], entry_count[26:11],
  // entries_used[35:27], cursor[46:36], zero pad
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int EAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW  = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [COUNT_WIDTH-1:0] cnt;
  } entry_t;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_CLR  = 14'b00000000000010,
    S_TXT  = 14'b00000000000100,
    S_BRD  = 14'b00000000001000,
    S_BCMP = 14'b00000000010000,
    S_BEND = 14'b00000000100000,
    S_RRD  = 14'b00000001000000,
    S_RDE  = 14'b00000010000000,
    S_FRD  = 14'b00000100000000,
    S_FCMP = 14'b00001000000000,
    S_INS  = 14'b00010000000000,
    S_SRD  = 14'b00100000000000,
    S_SWR  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  logic [KEY_W-1:0] text_mem [TEXT_DEPTH];
  entry_t           ent_mem  [TABLE_DEPTH];

  state_t                state_r, state_nxt;
  logic [CURSOR_W-1:0]   cursor_r, cursor_nxt;
  logic [UW-1:0]         used_r, used_nxt;
  logic                  ranked_r, ranked_nxt;
  logic [CFG_DATA_W-1:0] len_r, len_nxt;
  logic [KEY_W-1:0]      era_r, era_nxt;
  logic [KEY_W-1:0]      erb_r, erb_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_W-1:0]      want_r, want_nxt;
  logic                  rank_mode_r, rank_mode_nxt;
  logic                  swapped_r, swapped_nxt;
  logic [UW-1:0]         j_r, j_nxt;
  logic [UW-1:0]         lo_r, lo_nxt;
  entry_t                cur_r, cur_nxt;
  logic [TAW-1:0]        clr_r, clr_nxt;
  logic [EAW-1:0]        ra_r, ra_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  res_miss_r, res_miss_nxt;
  logic [KEY_W-1:0]      res_key_r, res_key_nxt;
  logic [ECOUNT_W-1:0]   res_count_r, res_count_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic [KEY_W-1:0]      t_rdata_r;
  entry_t                e_rdata_r;

  logic                  t_we;
  logic [TAW-1:0]        t_wa;
  logic [KEY_W-1:0]      t_wd;
  logic                  e_we;
  logic [EAW-1:0]        e_wa;
  entry_t                e_wd;
  logic [EAW-1:0]        e_ra;

  logic [FUNC_W-1:0]     in_func;
  logic [IDX_W-1:0]      in_idx;
  logic [KEY_W-1:0]      in_key;
  logic [UW-1:0]         jm1;
  logic                  swap_c;
  logic [COUNT_WIDTH-1:0] newcnt_c;

  assign in_func   = in_tdata[2:0];
  assign in_idx    = in_tdata[12:3];
  assign in_key    = in_tdata[20:13];
  assign jm1       = j_r - 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign swap_c = rank_mode_r ?
      ((cur_r.cnt < e_rdata_r.cnt) ||
       ((cur_r.cnt == e_rdata_r.cnt) && (cur_r.key > e_rdata_r.key))) :
      (cur_r.key > e_rdata_r.key);
  assign newcnt_c = (&e_rdata_r.cnt) ? e_rdata_r.cnt : e_rdata_r.cnt + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    used_nxt       = used_r;
    ranked_nxt     = ranked_r;
    len_nxt        = len_r;
    era_nxt        = era_r;
    erb_nxt        = erb_r;
    key_nxt        = key_r;
    want_nxt       = want_r;
    rank_mode_nxt  = rank_mode_r;
    swapped_nxt    = swapped_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    cur_nxt        = cur_r;
    clr_nxt        = clr_r;
    ra_nxt         = ra_r;
    res_status_nxt = res_status_r;
    res_miss_nxt   = res_miss_r;
    res_key_nxt    = res_key_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    t_we = 1'b0;
    t_wa = TAW'(in_idx);
    t_wd = in_key;
    e_we = 1'b0;
    e_wa = jm1[EAW-1:0];
    e_wd = cur_r;
    e_ra = j_r[EAW-1:0];

    if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_LEN: len_nxt = cfg_data;
        REG_ERASE_A:  era_nxt = cfg_data[KEY_W-1:0];
        REG_ERASE_B:  erb_nxt = cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_status_nxt = ST_OK;
          res_miss_nxt   = 1'b0;
          res_key_nxt    = '0;
          res_count_nxt  = '0;
          key_nxt        = in_key;
          state_nxt      = S_DONE;
          case (in_func)
            FN_LOAD: begin
              if (32'(in_idx) < TEXT_DEPTH) t_we = 1'b1;
              else res_status_nxt = ST_BAD;
            end
            FN_KEY: begin
              if (in_key == era_r || in_key == erb_r) begin
                if (cursor_r != '0) cursor_nxt = cursor_r - 1'b1;
              end else if (cursor_r >= len_r || 32'(cursor_r) >= TEXT_DEPTH) begin
                res_status_nxt = ST_PAST;
              end else begin
                state_nxt = S_TXT;
              end
            end
            FN_RANK: begin
              rank_mode_nxt = 1'b1;
              ra_nxt        = '0;
              if (32'(used_r) >= 2) begin
                j_nxt       = '0;
                swapped_nxt = 1'b0;
                state_nxt   = S_BRD;
              end else begin
                ranked_nxt = 1'b1;
                if (used_r != '0) state_nxt = S_RRD;
              end
            end
            FN_READ: begin
              if (32'(in_idx) < 32'(used_r)) begin
                ra_nxt    = EAW'(in_idx);
                state_nxt = S_RRD;
              end else begin
                res_status_nxt = ST_BAD;
              end
            end
            FN_CLEAR: begin
              used_nxt   = '0;
              cursor_nxt = '0;
              len_nxt    = '0;
              ranked_nxt = 1'b0;
              clr_nxt    = '0;
              state_nxt  = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        t_we = 1'b1;
        t_wa = clr_r;
        t_wd = '0;
        if (clr_r == TAW'(TEXT_DEPTH - 1)) state_nxt = S_DONE;
        else clr_nxt = clr_r + 1'b1;
      end
      S_TXT: begin
        cursor_nxt = cursor_r + 1'b1;
        if (t_rdata_r == key_r) begin
          state_nxt = S_DONE;
        end else begin
          want_nxt     = t_rdata_r;
          res_miss_nxt = 1'b1;
          res_key_nxt  = t_rdata_r;
          j_nxt        = '0;
          if (ranked_r && 32'(used_r) >= 2) begin
            rank_mode_nxt = 1'b0;
            swapped_nxt   = 1'b0;
            state_nxt     = S_BRD;
          end else begin
            ranked_nxt = 1'b0;
            state_nxt  = S_FRD;
          end
        end
      end
      S_BRD: begin
        e_ra      = j_r[EAW-1:0];
        state_nxt = S_BCMP;
      end
      S_BCMP: begin
        if (j_r == '0) begin
          cur_nxt   = e_rdata_r;
          j_nxt     = UW'(1);
          state_nxt = S_BRD;
        end else begin
          e_we = 1'b1;
          e_wa = jm1[EAW-1:0];
          e_wd = swap_c ? e_rdata_r : cur_r;
          if (!swap_c) cur_nxt = e_rdata_r;
          if (swap_c) swapped_nxt = 1'b1;
          j_nxt = j_r + 1'b1;
          if ((j_r + 1'b1) == used_r) state_nxt = S_BEND;
          else state_nxt = S_BRD;
        end
      end
      S_BEND: begin
        e_we = 1'b1;
        e_wa = EAW'(used_r - 1'b1);
        e_wd = cur_r;
        j_nxt = '0;
        if (swapped_r) begin
          swapped_nxt = 1'b0;
          state_nxt   = S_BRD;
        end else if (rank_mode_r) begin
          ranked_nxt = 1'b1;
          ra_nxt     = '0;
          state_nxt  = S_RRD;
        end else begin
          ranked_nxt = 1'b0;
          state_nxt  = S_FRD;
        end
      end
      S_RRD: begin
        e_ra      = ra_r;
        state_nxt = S_RDE;
      end
      S_RDE: begin
        res_key_nxt   = e_rdata_r.key;
        res_count_nxt = ECOUNT_W'(e_rdata_r.cnt);
        state_nxt     = S_DONE;
      end
      S_FRD: begin
        if (j_r == used_r) begin
          lo_nxt    = j_r;
          state_nxt = S_INS;
        end else begin
          e_ra      = j_r[EAW-1:0];
          state_nxt = S_FCMP;
        end
      end
      S_FCMP: begin
        if (e_rdata_r.key == want_r) begin
          e_we          = 1'b1;
          e_wa          = j_r[EAW-1:0];
          e_wd          = '{key: want_r, cnt: newcnt_c};
          res_count_nxt = ECOUNT_W'(newcnt_c);
          state_nxt     = S_DONE;
        end else if (e_rdata_r.key > want_r) begin
          lo_nxt    = j_r;
          state_nxt = S_INS;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_INS: begin
        if (32'(used_r) == TABLE_DEPTH) begin
          res_count_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          j_nxt     = used_r;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (j_r == lo_r) begin
          e_we          = 1'b1;
          e_wa          = lo_r[EAW-1:0];
          e_wd          = '{key: want_r, cnt: COUNT_WIDTH'(1)};
          used_nxt      = used_r + 1'b1;
          res_count_nxt = ECOUNT_W'(1);
          state_nxt     = S_DONE;
        end else begin
          e_ra      = jm1[EAW-1:0];
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        e_we      = 1'b1;
        e_wa      = j_r[EAW-1:0];
        e_wd      = e_rdata_r;
        j_nxt     = jm1;
        state_nxt = S_SRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cursor_r, EUSED_W'(used_r), res_count_r, res_key_r,
                           res_miss_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      used_r      <= '0;
      ranked_r    <= 1'b0;
      len_r       <= '0;
      era_r       <= ERASE_A_RST;
      erb_r       <= ERASE_B_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      ranked_r    <= ranked_nxt;
      len_r       <= len_nxt;
      era_r       <= era_nxt;
      erb_r       <= erb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    want_r       <= want_nxt;
    rank_mode_r  <= rank_mode_nxt;
    swapped_r    <= swapped_nxt;
    j_r          <= j_nxt;
    lo_r         <= lo_nxt;
    cur_r        <= cur_nxt;
    clr_r        <= clr_nxt;
    ra_r         <= ra_nxt;
    res_status_r <= res_status_nxt;
    res_miss_r   <= res_miss_nxt;
    res_key_r    <= res_key_nxt;
    res_count_r  <= res_count_nxt;
    out_data_r   <= out_data_nxt;
  end

  // text store: one write port, read at the cursor
  always_ff @(posedge clk) begin
    if (t_we) text_mem[t_wa] <= t_wd;
    t_rdata_r <= text_mem[TAW'(cursor_r)];
  end

  // entry table: one write port, one read port
  always_ff @(posedge clk) begin
    if (e_we) ent_mem[e_wa] <= e_wd;
    e_rdata_r <= ent_mem[e_ra];
  end

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for keyed_mistake_count_table_core.
// Directed table, then random typing sessions checked by an in-bench predictor.
// Depends on kmct_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import kmct_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                miss;
    logic [KEY_W-1:0]    ekey;
    logic [ECOUNT_W-1:0] ecount;
    logic [EUSED_W-1:0]  used;
    logic [CURSOR_W-1:0] cursor;
  } tally_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    int                idx;
    int                key;
    int                set_len;
    bit                typed;
    logic [STATUS_W-1:0] status;
  } drow_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TEXT_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keyed_mistake_count_table_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [KEY_W-1:0]    txt_mem [DEF_TEXT_DEPTH];
  int                  txt_pos;
  logic [KEY_W-1:0]    tbl_key [DEF_TABLE_DEPTH];
  int                  tbl_cnt [DEF_TABLE_DEPTH];
  int                  tbl_used;
  bit                  tbl_ranked;
  int                  len_reg;
  logic [KEY_W-1:0]    era, erb;

  tally_t tally_q[$];
  drow_t  dir_q[$];
  int     errors, n_items, n_miss, n_rank, n_done;
  int     send_idle, recv_idle;
  int     hold_req, hold_left;

  function automatic void swap_ent(int a, int b);
    logic [KEY_W-1:0] k;
    int c;
    k = tbl_key[a]; c = tbl_cnt[a];
    tbl_key[a] = tbl_key[b]; tbl_cnt[a] = tbl_cnt[b];
    tbl_key[b] = k; tbl_cnt[b] = c;
  endfunction

  function automatic void sort_keys();
    for (int i = 1; i < tbl_used; i++)
      for (int j = i; j > 0 && tbl_key[j-1] > tbl_key[j]; j--) swap_ent(j-1, j);
  endfunction

  function automatic bit ranks_lower(int a, int b);
    if (tbl_cnt[a] != tbl_cnt[b]) return tbl_cnt[a] < tbl_cnt[b];
    return tbl_key[a] > tbl_key[b];
  endfunction

  function automatic void sort_ranks();
    for (int i = 1; i < tbl_used; i++)
      for (int j = i; j > 0 && ranks_lower(j-1, j); j--) swap_ent(j-1, j);
  endfunction

  function automatic int bump_count(logic [KEY_W-1:0] k);
    int lo, hi, mid;
    lo = 0; hi = tbl_used;
    if (tbl_ranked) begin
      sort_keys();
      tbl_ranked = 0;
    end
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_key[mid] < k) lo = mid + 1;
      else if (tbl_key[mid] > k) hi = mid;
      else begin
        if (tbl_cnt[mid] < (1 << DEF_COUNT_WIDTH) - 1) tbl_cnt[mid]++;
        return tbl_cnt[mid];
      end
    end
    if (tbl_used >= DEF_TABLE_DEPTH) return 0;
    for (int i = tbl_used; i > lo; i--) begin
      tbl_key[i] = tbl_key[i-1];
      tbl_cnt[i] = tbl_cnt[i-1];
    end
    tbl_key[lo] = k;
    tbl_cnt[lo] = 1;
    tbl_used++;
    return 1;
  endfunction

  function automatic tally_t predict_item(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                          logic [KEY_W-1:0] key);
    tally_t r;
    int lim;
    r = '{ST_OK, 1'b0, '0, '0, '0, '0};
    lim = len_reg < DEF_TEXT_DEPTH ? len_reg : DEF_TEXT_DEPTH;
    case (fn)
      FN_LOAD: begin
        txt_mem[idx] = key;
      end
      FN_KEY: begin
        if (key == era || key == erb) begin
          if (txt_pos > 0) txt_pos--;
        end else if (txt_pos >= lim) begin
          r.status = ST_PAST;
        end else begin
          if (key != txt_mem[txt_pos]) begin
            r.miss = 1'b1;
            r.ekey = txt_mem[txt_pos];
            r.ecount = ECOUNT_W'(bump_count(txt_mem[txt_pos]));
            n_miss++;
          end
          txt_pos++;
        end
      end
      FN_RANK: begin
        sort_ranks();
        tbl_ranked = 1;
        n_rank++;
        if (tbl_used > 0) begin
          r.ekey = tbl_key[0];
          r.ecount = ECOUNT_W'(tbl_cnt[0]);
        end
      end
      FN_READ: begin
        if (idx < tbl_used) begin
          r.ekey = tbl_key[idx];
          r.ecount = ECOUNT_W'(tbl_cnt[idx]);
        end else r.status = ST_BAD;
      end
      FN_CLEAR: begin
        foreach (txt_mem[i]) txt_mem[i] = '0;
        len_reg = 0;
        txt_pos = 0;
        tbl_used = 0;
        tbl_ranked = 0;
      end
      default: ;
    endcase
    r.used = EUSED_W'(tbl_used);
    r.cursor = CURSOR_W'(txt_pos);
    return r;
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] fn, int idx, int key, bit typed = 0,
                           logic [STATUS_W-1:0] st = ST_OK);
    tally_t p;
    logic [IDX_W-1:0] ix;
    logic [KEY_W-1:0] kx;
    ix = IDX_W'(idx);
    kx = KEY_W'(key);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W-21){1'b0}}, kx, ix, fn};
    do @(posedge clk); while (!in_tready);
    p = predict_item(fn, ix, kx);
    if (typed) p = '{st, 1'b0, '0, '0, '0, '0};
    tally_q.push_back(p);
    n_items++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    wait (tally_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, int val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ri)
      REG_TEXT_LEN: len_reg = val & 11'h7FF;
      REG_ERASE_A:  era = KEY_W'(val);
      default:      erb = KEY_W'(val);
    endcase
  endtask

  function automatic void add_row(logic [FUNC_W-1:0] fn, int idx, int key, int set_len = -1,
                                  bit typed = 0, logic [STATUS_W-1:0] st = ST_OK);
    dir_q.push_back('{fn, idx, key, set_len, typed, st});
  endfunction

  function automatic int pick_stroke();
    int r;
    r = $urandom_range(99);
    if (r < 45 && txt_pos < len_reg && txt_pos < DEF_TEXT_DEPTH) return int'(txt_mem[txt_pos]);
    if (r < 80) return int'($urandom_range(255));
    return r < 90 ? int'(era) : int'(erb);
  endfunction

  // result side: checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        tally_t g, w;
        g = '{out_tdata[1:0], out_tdata[2], out_tdata[10:3], out_tdata[26:11],
              out_tdata[35:27], out_tdata[46:36]};
        n_done++;
        if (tally_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: %p", g);
        end else begin
          w = tally_q.pop_front();
          if (g != w) begin
            errors++;
            if (errors <= 10) $display("mismatch at result %0d: want %p got %p", n_done, w, g);
          end
        end
      end
    end
  end

  // result side: random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    #500_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n, cnt;
    logic [FUNC_W-1:0] fn;
    errors = 0; n_items = 0; n_miss = 0; n_rank = 0; n_done = 0;
    hold_req = 0; hold_left = 0;
    send_idle = 22; recv_idle = 75;
    len_reg = 0; era = ERASE_A_RST; erb = ERASE_B_RST;
    txt_pos = 0; tbl_used = 0; tbl_ranked = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty state after reset, then a short typed text
    add_row(FN_READ, 0, 0, -1, 1, ST_BAD);
    add_row(FN_KEY, 0, 8'h61, -1, 1, ST_PAST);
    add_row(FN_KEY, 0, 8, -1, 1, ST_OK);
    add_row(FN_RANK, 0, 0, -1, 1, ST_OK);
    add_row(3'd7, 10'h3FF, 8'hFF, -1, 1, ST_OK);
    add_row(FN_CLEAR, 0, 0, -1, 1, ST_OK);
    add_row(FN_LOAD, 0, 8'h78, 4);
    add_row(FN_LOAD, 1, 8'hFF);
    add_row(FN_LOAD, 10'h3FF, 8'h00);
    add_row(FN_LOAD, 3, 8'h41);
    add_row(FN_KEY, 0, 8'h78);
    add_row(FN_KEY, 0, 8'h00);
    add_row(FN_KEY, 0, 8'd127);
    add_row(FN_KEY, 0, 8'hFE);
    add_row(FN_KEY, 0, 8'hFF);
    add_row(FN_KEY, 0, 8'h41);
    add_row(FN_KEY, 0, 8'h42);
    add_row(FN_RANK, 0, 0);
    add_row(FN_READ, 0, 0);
    add_row(FN_READ, 1, 0);
    add_row(FN_READ, 2, 0);
    add_row(FN_READ, 10'h3FF, 0);
    add_row(FN_KEY, 0, 8'd8);
    add_row(FN_KEY, 0, 8'h99);
    add_row(FN_READ, 1, 0);
    foreach (dir_q[i]) begin
      if (dir_q[i].set_len >= 0) write_reg(REG_TEXT_LEN, dir_q[i].set_len);
      send_item(dir_q[i].fn, dir_q[i].idx, dir_q[i].key, dir_q[i].typed, dir_q[i].status);
    end

    // fill the table with every key, rank the full table, then update after rank
    write_reg(REG_TEXT_LEN, 2047);
    write_reg(REG_ERASE_A, 0);
    write_reg(REG_ERASE_B, 255);
    for (int i = 0; i < 264; i++) send_item(FN_LOAD, i, i);
    for (int i = 0; i < 264; i++)
      send_item(FN_KEY, 0, (i < 256 || $urandom_range(1)) ? (i + 1 + $urandom_range(250)) % 256
                                                            : i % 256);
    send_item(FN_RANK, 0, 0);
    for (int i = 0; i < 12; i++) send_item(FN_READ, $urandom_range(255), 0);
    send_item(FN_READ, 256, 0);
    send_item(FN_KEY, 0, 8'h5A);
    send_item(FN_CLEAR, 0, 0);

    // random typing sessions
    for (int s = 0; n_items < 1420; s++) begin
      if (n_items > 1100) begin
        send_idle = 0; recv_idle = 0;
      end else if (n_items > 820) begin
        send_idle = 75; recv_idle = 22;
      end
      if ($urandom_range(3) == 0) write_reg(REG_ERASE_A, $urandom_range(255));
      if ($urandom_range(3) == 0) write_reg(REG_ERASE_B, $urandom_range(255));
      case ($urandom_range(9))
        0: n = 0;
        1: n = 1024;
        default: n = $urandom_range(4, 40);
      endcase
      write_reg(REG_TEXT_LEN, n);
      if ($urandom_range(2) == 0) send_item(FN_CLEAR, 0, 0);
      if (tbl_used > 80) send_item(FN_CLEAR, 0, 0);
      if (len_reg == 0 && $urandom_range(1)) write_reg(REG_TEXT_LEN, $urandom_range(3, 30));
      for (int i = 0; i < len_reg && i < 40; i++) send_item(FN_LOAD, i, $urandom_range(255));
      cnt = $urandom_range(20, 60);
      for (int i = 0; i < cnt; i++) begin
        if (s == 2 && i == 5) hold_req = 1;
        if (s == 3 && i == 10) wait_drained();
        n = $urandom_range(99);
        if (n < 62) send_item(FN_KEY, 0, pick_stroke());
        else if (n < 72) send_item(FN_LOAD, $urandom_range(1023), $urandom_range(255));
        else if (n < 86)
          send_item(FN_READ, $urandom_range(3) == 0 ? $urandom_range(1023)
                                                    : $urandom_range(tbl_used + 1), 0);
        else if (n < 93) send_item(FN_RANK, 0, 0);
        else if (n < 97) begin
          fn = FUNC_W'($urandom_range(5, 7));
          send_item(fn, $urandom_range(1023), $urandom_range(255));
        end else send_item(FN_CLEAR, 0, 0);
      end
    end

    in_tvalid <= 1'b0;
    wait (tally_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d items: %0d counted mistakes, %0d rank commands, %0d results checked.",
             n_items, n_miss, n_rank, n_done);
    if (errors == 0 && tally_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/kmct_pkg.sv
rtl/core/keyed_mistake_count_table_core.sv
test/tb_top.sv
